@@ rtl/bdpc_pkg.sv @@
// Package for the button debounce / press classifier.
// Types, codes and widths shared by all rtl/bdpc_* modules and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bdpc_pkg;

    // Counter width for debounce, held and repeat counters (4..16)
    localparam int CNT_W = 8;
    // Config register width (fixed by the register map)
    localparam int CFG_W = 8;
    // Compare width covering both counter and threshold
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IDX_W = 2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [CFG_W-1:0] t_cfg;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_STABLE_TICKS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REPEAT_TICKS = 2'd2;
    localparam logic [IDX_W-1:0] CFG_ACTIVE_LEVEL = 2'd3;

    // Register reset values
    localparam t_cfg RST_STABLE_TICKS = 8'd2;
    localparam t_cfg RST_LONG_TICKS   = 8'd50;
    localparam t_cfg RST_REPEAT_TICKS = 8'd10;
    localparam logic RST_ACTIVE_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DOWN = 2'd1,
        ST_UP   = 2'd2,
        ST_BAD  = 2'd3
    } t_press;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CLICK = 2'd1,
        PEND_LONG  = 2'd2,
        PEND_BAD   = 2'd3
    } t_pend;

    typedef enum logic [1:0] {
        EV_CLICK        = 2'd0,
        EV_LONG         = 2'd1,
        EV_LONG_RELEASE = 2'd2,
        EV_BAD          = 2'd3
    } t_event;

    typedef struct packed {
        t_cfg stable_ticks;
        t_cfg long_ticks;
        t_cfg repeat_ticks;
        logic active_level;
    } t_cfg_regs;

    // Result of one tick: fire flag plus event
    typedef struct packed {
        logic   fire;
        t_event code;
    } t_result;

    // Zero-extend a counter to compare width
    function automatic logic [CMP_W-1:0] cnt_ext(input t_cnt c);
        return CMP_W'(c);
    endfunction

    function automatic logic [CMP_W-1:0] cfg_ext(input t_cfg c);
        return CMP_W'(c);
    endfunction

endpackage
`default_nettype wire

@@ rtl/bdpc_core.sv @@
// Debounce and press classification state with its one-tick update logic.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdpc_core
    import bdpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg_regs i_cfg,
    input  wire logic      i_step,
    input  wire logic      i_level,
    output t_result        o_result
);

    logic   r_stable;
    t_cnt   r_deb;
    t_press r_ps;
    t_pend  r_pend;
    t_cnt   r_held;
    t_cnt   r_rpt;

    logic   n_stable;
    t_cnt   n_deb;
    t_press n_ps;
    t_press mid_ps;
    t_pend  n_pend;
    t_cnt   n_held;
    t_cnt   n_rpt;
    t_result res;

    t_cnt deb_inc;
    t_cnt held_inc;
    t_cnt rpt_inc;
    logic [CMP_W:0] long_p1;

    assign deb_inc  = r_deb + 1'b1;
    assign held_inc = r_held + 1'b1;
    assign rpt_inc  = r_rpt + 1'b1;
    assign long_p1  = (CMP_W+1)'(i_cfg.long_ticks) + 1'b1;

    // Debounce and press state
    always_comb begin
        n_stable = r_stable;
        n_deb    = r_deb;
        mid_ps   = r_ps;
        if (i_level != r_stable) begin
            if (cnt_ext(deb_inc) > cfg_ext(i_cfg.stable_ticks)) begin
                n_stable = i_level;
                n_deb    = '0;
                if (r_ps == ST_IDLE && i_level == i_cfg.active_level) begin
                    mid_ps = ST_DOWN;
                end else if (r_ps == ST_DOWN) begin
                    mid_ps = ST_UP;
                end
            end else begin
                n_deb = deb_inc;
            end
        end else begin
            n_deb = '0;
        end
        case (mid_ps)
            ST_IDLE: n_ps = ST_IDLE;
            ST_DOWN: n_ps = ST_DOWN;
            default: n_ps = ST_IDLE;
        endcase
    end

    // Held / repeat counters, pending event and result
    always_comb begin
        n_held = r_held;
        n_rpt  = r_rpt;
        n_pend = r_pend;
        res.fire = 1'b0;
        res.code = EV_CLICK;
        case (mid_ps)
            ST_DOWN: begin
                if (n_stable == i_cfg.active_level) begin
                    n_held = held_inc;
                    if (cnt_ext(held_inc) < cfg_ext(i_cfg.long_ticks)) begin
                        n_pend = PEND_CLICK;
                    end else if (cnt_ext(held_inc) == cfg_ext(i_cfg.long_ticks)) begin
                        n_pend   = PEND_LONG;
                        res.fire = 1'b1;
                        res.code = EV_LONG;
                    end else begin
                        n_rpt = rpt_inc;
                        if (cnt_ext(rpt_inc) >= cfg_ext(i_cfg.repeat_ticks)) begin
                            n_rpt    = '0;
                            n_pend   = PEND_LONG;
                            res.fire = 1'b1;
                            res.code = EV_LONG;
                        end
                    end
                    // saturate by jumping back above the long threshold
                    if (held_inc == '1) begin
                        n_held = long_p1[CNT_W-1:0];
                    end
                end
            end
            ST_UP: begin
                if (r_pend == PEND_CLICK) begin
                    res.fire = 1'b1;
                    res.code = EV_CLICK;
                    n_held   = '0;
                end else if (r_pend == PEND_LONG) begin
                    res.fire = 1'b1;
                    res.code = EV_LONG_RELEASE;
                    n_held   = '0;
                    n_rpt    = '0;
                end
                n_pend = PEND_NONE;
            end
            ST_IDLE: begin
            end
            default: begin
                n_pend = PEND_NONE;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_deb    <= '0;
            r_ps     <= ST_IDLE;
            r_pend   <= PEND_NONE;
            r_held   <= '0;
            r_rpt    <= '0;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_deb    <= n_deb;
            r_ps     <= n_ps;
            r_pend   <= n_pend;
            r_held   <= n_held;
            r_rpt    <= n_rpt;
        end
    end

    // Only idle and down survive a tick
    a_ps_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ps == ST_IDLE || r_ps == ST_DOWN)
        else $error("press state left idle/down");

    // A click comes only from a pending click
    a_click_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.fire && res.code == EV_CLICK) |-> r_pend == PEND_CLICK)
        else $error("click without pending click");

    // State holds between steps
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_stable) && $stable(r_held) && $stable(r_deb)))
        else $error("state moved without a step");

    // A release result clears the held counter
    a_release_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.fire && res.code != EV_LONG) |=> r_held == '0)
        else $error("held count not cleared on release");

endmodule
`default_nettype wire

@@ rtl/bdpc_obuf.sv @@
// Output result register with valid/ready handshake.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdpc_obuf
    import bdpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_event i_code,
    output logic        o_free,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_event      o_code
);

    logic   r_valid;
    t_event r_code;

    // free when empty or drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_code  = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= i_code;
        end
    end

endmodule
`default_nettype wire

@@ rtl/button_debounce_press_classifier.sv @@
// Channel    | Signals                               | Dir | Notes
// level in   | i_valid, o_ready, i_level             | in  | one sampled level per transfer
// event out  | o_valid, i_ready, o_event_code        | out | zero or one event per level
// config     | i_cfg_we, i_cfg_idx, i_cfg_data       | in  | write-only, no wait
//
// Cycles: one level per clock while o_ready stays high; an event's level is
// held in the input register, and the event is then presented from the result
// register (input register, then result register).
// The state update is the debounce compare plus held/repeat compare chain.
// Reset (synchronous, active low) restores config defaults and released state.
// A level with no event moves on even while the output is stalled; a level
// that makes an event waits in the input register until the result register
// frees, and o_ready drops meanwhile.
// Top level; depends on bdpc_pkg, bdpc_core, bdpc_obuf.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // level channel
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_level,
    // event channel
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [1:0]            o_event_code,
    // config write port
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // Configuration registers
    t_cfg_regs r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_ticks <= RST_STABLE_TICKS;
            r_cfg.long_ticks   <= RST_LONG_TICKS;
            r_cfg.repeat_ticks <= RST_REPEAT_TICKS;
            r_cfg.active_level <= RST_ACTIVE_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STABLE_TICKS: r_cfg.stable_ticks <= i_cfg_data;
                CFG_LONG_TICKS:   r_cfg.long_ticks   <= i_cfg_data;
                CFG_REPEAT_TICKS: r_cfg.repeat_ticks <= i_cfg_data;
                CFG_ACTIVE_LEVEL: r_cfg.active_level <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    logic r_in_valid;
    logic r_in_level;

    t_result core_res;
    logic    obuf_free;
    logic    step;
    t_event  out_code;

    // A held level advances when it emits nothing or the result slot is free
    assign step    = r_in_valid && (obuf_free || !core_res.fire);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_level <= i_level;
        end
    end

    bdpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (step),
        .i_level  (r_in_level),
        .o_result (core_res)
    );

    bdpc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && core_res.fire),
        .i_code  (core_res.code),
        .o_free  (obuf_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_code  (out_code)
    );

    assign o_event_code = out_code;

endmodule
`default_nettype wire
